/* hw/rtl/lut3d_pkg.sv */
// lut3d_pkg: shared types and constants of the 3d lut trilinear interpolator
// beat structs, register indexes, action codes and parameter defaults
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lut3d_pkg;

    // parameter defaults
    localparam int DEF_SIDE      = 32;
    localparam int DEF_FRAC_BITS = 16;

    // width used for raw grid address arithmetic (morton of 8-bit indexes)
    localparam int ADDR_CALC_W = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_Z    = 3'd6;

    // reset value of the reciprocal cell size registers (1.0 in q16.16)
    localparam logic [31:0] INV_CELL_RESET = 32'h0001_0000;

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // address order codes
    localparam logic ORDER_LINEAR = 1'b0;
    localparam logic ORDER_MORTON = 1'b1;

    typedef struct packed {
        logic               action;
        logic [4:0]         cell_x;
        logic [4:0]         cell_y;
        logic [4:0]         cell_z;
        logic signed [31:0] sample_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } lut3d_in_t;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic               clamped;
    } lut3d_out_t;

endpackage

`default_nettype wire

/* hw/rtl/lut3d_grid_ram.sv */
// lut3d_grid_ram: single-port grid sample memory with registered read data
// one shared address for write and read; depends on lut3d_pkg for defaults
`timescale 1ns / 1ps
`default_nettype none

module lut3d_grid_ram #(
    parameter int DEPTH  = lut3d_pkg::DEF_SIDE * lut3d_pkg::DEF_SIDE * lut3d_pkg::DEF_SIDE,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [31:0]       wdata,
    output logic [31:0]            rdata
);

    logic [31:0] mem [DEPTH];

    // write port and registered read, read-first
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* hw/rtl/lut3d_trilinear_interpolator_top.sv */
// lut3d_trilinear_interpolator_top: grid store and trilinear query sequencer
// a write beat produces no result; a query beat is followed by no new beat until its result
// is handed to the result register and the sequencer is idle again; a query makes 10 passes
// through the one shared multiplier and 8 reads of the single-port grid ram
// synchronous active-low reset clears control and config registers; grid contents are
// undefined until written, no clearing pass; depends on lut3d_pkg, lut3d_grid_ram
`timescale 1ns / 1ps
`default_nettype none

module lut3d_trilinear_interpolator_top #(
    parameter int SIDE      = lut3d_pkg::DEF_SIDE,
    parameter int FRAC_BITS = lut3d_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // config write port
    input  wire logic                                cfg_we,
    input  wire logic [lut3d_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lut3d_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input beats
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire lut3d_pkg::lut3d_in_t                s_data,
    // result beats
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output lut3d_pkg::lut3d_out_t                    m_data
);

    localparam int CW     = lut3d_pkg::ADDR_CALC_W;
    localparam int DEPTH  = SIDE * SIDE * SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int IDXW   = $clog2(SIDE);
    localparam int FB_PAD = 33 - FRAC_BITS;

    localparam logic [CW-1:0]   SIDE_C  = CW'(SIDE);
    localparam logic [CW-1:0]   DEPTH_C = CW'(DEPTH);
    localparam logic [63:0]     LIMIT   = 64'(SIDE - 1) << FRAC_BITS;
    localparam logic [IDXW-1:0] IDX_TOP = IDXW'(SIDE - 1);

    localparam logic [1:0] AX_LAST   = 2'd2;
    localparam logic [3:0] RD_LAST   = 4'd9;
    localparam logic [3:0] RD_CAP0   = 4'd2;
    localparam logic [3:0] RD_ISSUED = 4'd8;
    localparam logic [2:0] LERP_LAST = 3'd6;
    localparam logic [2:0] LERP_Y0   = 3'd4;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_AX_SUB = 3'd1;
    localparam logic [2:0] S_AX_MUL = 3'd2;
    localparam logic [2:0] S_AX_FIN = 3'd3;
    localparam logic [2:0] S_RD     = 3'd4;
    localparam logic [2:0] S_LP_SUB = 3'd5;
    localparam logic [2:0] S_LP_MUL = 3'd6;
    localparam logic [2:0] S_LP_ADD = 3'd7;

    // raw grid address, linear x-fastest or morton interleaved
    function automatic logic [CW-1:0] grid_addr(input logic morton, input logic [7:0] x,
                                                input logic [7:0] y, input logic [7:0] z);
        logic [CW-1:0] a;
        a = '0;
        if (morton == lut3d_pkg::ORDER_MORTON) begin
            for (int i = 0; i < 8; i++) begin
                a[3*i]   = x[i];
                a[3*i+1] = y[i];
                a[3*i+2] = z[i];
            end
        end else begin
            a = CW'(x) + SIDE_C * (CW'(y) + SIDE_C * CW'(z));
        end
        return a;
    endfunction

    // config registers
    logic               address_order_reg;
    logic signed [31:0] origin_reg   [3];
    logic [31:0]        inv_cell_reg [3];

    // control
    logic [2:0] state_reg, state_next;
    logic [1:0] ax_cnt_reg;
    logic [3:0] rd_cnt_reg;
    logic [2:0] lerp_cnt_reg;
    logic [3:0] qlen_reg;
    logic       m_valid_reg;

    // datapath
    lut3d_pkg::lut3d_in_t   item_reg;
    lut3d_pkg::lut3d_out_t  m_data_reg;
    logic signed [33:0]     op_a_reg;
    logic signed [32:0]     op_b_reg;
    logic signed [66:0]     product_reg;
    logic                   neg_reg;
    logic                   invnz_reg;
    logic                   cl_reg;
    logic [IDXW-1:0]        lo_reg [3];
    logic [IDXW-1:0]        hi_reg [3];
    logic [FRAC_BITS-1:0]   fr_reg [3];
    logic [AW-1:0]          addr_reg;
    logic                   addr_ok_reg;
    logic                   rd_ok_reg;
    logic signed [31:0]     a_reg;
    logic signed [31:0]     q_reg [8];

    logic [31:0] ram_rdata;
    logic        ram_we;
    logic [AW-1:0] ram_addr;

    logic accept;
    logic finish;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign finish  = (state_reg == S_LP_ADD) && (lerp_cnt_reg == LERP_LAST) &&
                     (!m_valid_reg || m_ready);

    // write beat address
    logic [CW-1:0] waddr_raw;
    logic          waddr_ok;
    assign waddr_raw = grid_addr(address_order_reg, 8'(s_data.cell_x), 8'(s_data.cell_y),
                                 8'(s_data.cell_z));
    assign waddr_ok  = (waddr_raw < DEPTH_C);

    // corner address for the read sequence: bit 2 picks x side, bit 1 y, bit 0 z
    logic [IDXW-1:0] cx, cy, cz;
    logic [CW-1:0]   caddr_raw;
    always_comb begin
        cx = rd_cnt_reg[2] ? hi_reg[0] : lo_reg[0];
        cy = rd_cnt_reg[1] ? hi_reg[1] : lo_reg[1];
        cz = rd_cnt_reg[0] ? hi_reg[2] : lo_reg[2];
        caddr_raw = grid_addr(address_order_reg, 8'(cx), 8'(cy), 8'(cz));
    end

    // ram port: input writes while idle, corner reads otherwise
    assign ram_we   = accept && (s_data.action == lut3d_pkg::ACT_WRITE) && waddr_ok;
    assign ram_addr = (state_reg == S_IDLE) ? waddr_raw[AW-1:0] : addr_reg;

    lut3d_grid_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_grid_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_data.sample_value),
        .rdata (ram_rdata)
    );

    // axis operand selection
    logic signed [31:0] ax_pos;
    logic signed [31:0] ax_org;
    logic [31:0]        ax_inv;
    logic signed [32:0] ax_diff;
    always_comb begin
        case (ax_cnt_reg)
            2'd0: begin
                ax_pos = item_reg.pos_x;
                ax_org = origin_reg[0];
                ax_inv = inv_cell_reg[0];
            end
            2'd1: begin
                ax_pos = item_reg.pos_y;
                ax_org = origin_reg[1];
                ax_inv = inv_cell_reg[1];
            end
            default: begin
                ax_pos = item_reg.pos_z;
                ax_org = origin_reg[2];
                ax_inv = inv_cell_reg[2];
            end
        endcase
        ax_diff = {ax_pos[31], ax_pos} - {ax_org[31], ax_org};
    end

    // axis finish: grid coordinate, clamp to grid, split index and fraction
    logic [63:0]     t_raw;
    logic            t_over;
    logic [63:0]     t_val;
    logic [IDXW-1:0] t_lo;
    logic            t_cl;
    always_comb begin
        t_raw  = product_reg[63:0] >> FRAC_BITS;
        t_over = (t_raw > LIMIT);
        if (neg_reg) begin
            t_val = '0;
            t_cl  = invnz_reg;
        end else begin
            t_val = t_over ? LIMIT : t_raw;
            t_cl  = t_over;
        end
        t_lo = t_val[FRAC_BITS +: IDXW];
    end

    // lerp fraction: z for the first four, y for the next two, x last
    logic [FRAC_BITS-1:0] lerp_f;
    always_comb begin
        if (lerp_cnt_reg < LERP_Y0) begin
            lerp_f = fr_reg[2];
        end else if (lerp_cnt_reg < LERP_LAST) begin
            lerp_f = fr_reg[1];
        end else begin
            lerp_f = fr_reg[0];
        end
    end

    // lerp finish: a + floor(prod / 2^F), saturated
    logic signed [66:0] prod_sh;
    logic [33:0]        lerp_sum;
    logic [31:0]        lerp_sat;
    always_comb begin
        prod_sh  = product_reg >>> FRAC_BITS;
        lerp_sum = {{2{a_reg[31]}}, a_reg} + {prod_sh[32], prod_sh[32:0]};
        if (lerp_sum[33:31] == 3'b000 || lerp_sum[33:31] == 3'b111) begin
            lerp_sat = lerp_sum[31:0];
        end else if (lerp_sum[33]) begin
            lerp_sat = 32'h8000_0000;
        end else begin
            lerp_sat = 32'h7FFF_FFFF;
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && s_data.action == lut3d_pkg::ACT_QUERY) begin
                    state_next = S_AX_SUB;
                end
            end
            S_AX_SUB: state_next = S_AX_MUL;
            S_AX_MUL: state_next = S_AX_FIN;
            S_AX_FIN: state_next = (ax_cnt_reg == AX_LAST) ? S_RD : S_AX_SUB;
            S_RD:     state_next = (rd_cnt_reg == RD_LAST) ? S_LP_SUB : S_RD;
            S_LP_SUB: state_next = S_LP_MUL;
            S_LP_MUL: state_next = S_LP_ADD;
            S_LP_ADD: begin
                if (lerp_cnt_reg != LERP_LAST) begin
                    state_next = S_LP_SUB;
                end else if (finish) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // control registers and config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            ax_cnt_reg        <= '0;
            rd_cnt_reg        <= '0;
            lerp_cnt_reg      <= '0;
            qlen_reg          <= '0;
            m_valid_reg       <= 1'b0;
            address_order_reg <= lut3d_pkg::ORDER_LINEAR;
            for (int k = 0; k < 3; k++) begin
                origin_reg[k]   <= '0;
                inv_cell_reg[k] <= lut3d_pkg::INV_CELL_RESET;
            end
        end else begin
            state_reg <= state_next;

            // config writes
            if (cfg_we) begin
                unique case (cfg_index)
                    lut3d_pkg::REG_ADDRESS_ORDER: address_order_reg <= cfg_wdata[0];
                    lut3d_pkg::REG_ORIGIN_X:      origin_reg[0]     <= cfg_wdata;
                    lut3d_pkg::REG_ORIGIN_Y:      origin_reg[1]     <= cfg_wdata;
                    lut3d_pkg::REG_ORIGIN_Z:      origin_reg[2]     <= cfg_wdata;
                    lut3d_pkg::REG_INV_CELL_X:    inv_cell_reg[0]   <= cfg_wdata;
                    lut3d_pkg::REG_INV_CELL_Y:    inv_cell_reg[1]   <= cfg_wdata;
                    lut3d_pkg::REG_INV_CELL_Z:    inv_cell_reg[2]   <= cfg_wdata;
                    default: ;
                endcase
            end

            // counters
            if (accept) begin
                ax_cnt_reg   <= '0;
                rd_cnt_reg   <= '0;
                lerp_cnt_reg <= '0;
                qlen_reg     <= '0;
            end
            if (state_reg == S_AX_FIN) begin
                ax_cnt_reg <= ax_cnt_reg + 2'd1;
            end
            if (state_reg == S_RD) begin
                rd_cnt_reg <= rd_cnt_reg + 4'd1;
                if (rd_cnt_reg >= RD_CAP0) begin
                    qlen_reg <= qlen_reg + 4'd1;
                end
            end
            if (state_reg == S_LP_SUB) begin
                qlen_reg <= qlen_reg - 4'd2;
            end
            if (state_reg == S_LP_ADD && lerp_cnt_reg != LERP_LAST) begin
                qlen_reg     <= qlen_reg + 4'd1;
                lerp_cnt_reg <= lerp_cnt_reg + 3'd1;
            end

            // result beat
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
            cl_reg   <= 1'b0;
        end

        // shared multiplier
        product_reg <= op_a_reg * op_b_reg;

        unique case (state_reg)
            S_AX_SUB: begin
                op_a_reg  <= {ax_diff[32], ax_diff};
                op_b_reg  <= {1'b0, ax_inv};
                neg_reg   <= ax_diff[32];
                invnz_reg <= (ax_inv != 32'd0);
            end
            S_AX_FIN: begin
                lo_reg[ax_cnt_reg] <= t_lo;
                hi_reg[ax_cnt_reg] <= (t_lo == IDX_TOP) ? t_lo : t_lo + 1'b1;
                fr_reg[ax_cnt_reg] <= t_val[FRAC_BITS-1:0];
                cl_reg             <= cl_reg | t_cl;
            end
            S_RD: begin
                // three-step pipe: address, ram read, capture into the queue
                if (rd_cnt_reg < RD_ISSUED) begin
                    addr_reg    <= caddr_raw[AW-1:0];
                    addr_ok_reg <= (caddr_raw < DEPTH_C);
                end
                rd_ok_reg <= addr_ok_reg;
                if (rd_cnt_reg >= RD_CAP0) begin
                    q_reg[qlen_reg[2:0]] <= rd_ok_reg ? ram_rdata : 32'd0;
                end
            end
            S_LP_SUB: begin
                // pop the two head entries, set up (b - a) * f
                a_reg    <= q_reg[0];
                op_a_reg <= {q_reg[1][31], q_reg[1][31], q_reg[1]} -
                            {q_reg[0][31], q_reg[0][31], q_reg[0]};
                op_b_reg <= {{FB_PAD{1'b0}}, lerp_f};
                for (int i = 0; i < 6; i++) begin
                    q_reg[i] <= q_reg[i+2];
                end
            end
            S_LP_ADD: begin
                if (lerp_cnt_reg != LERP_LAST) begin
                    q_reg[qlen_reg[2:0]] <= lerp_sat;
                end
            end
            default: ;
        endcase

        if (finish) begin
            m_data_reg.interp_value <= lerp_sat;
            m_data_reg.clamped      <= cl_reg;
        end
    end

    // grid ram is only written from an input beat while idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg == S_IDLE)
        else $error("grid write outside idle");

    // all eight corners are queued when the read sequence ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD && rd_cnt_reg == RD_LAST) |=> qlen_reg == 4'd8)
        else $error("corner queue not full after reads");

    // the queue is empty once the last blend pops its operands
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LP_ADD && lerp_cnt_reg == LERP_LAST) |-> qlen_reg == 4'd0)
        else $error("corner queue not drained at last blend");

    // no new beat is taken while a query is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !accept)
        else $error("beat accepted during query");

endmodule

`default_nettype wire
